[hw/rtl/scpa_pkg.sv]
// Package for the seconds clock with periodic alarm.
// Holds field widths, the watchdog grace, register reset values and register and item-kind codes.
// No dependencies.
package scpa_pkg;

    localparam int unsigned TIME_W      = 32;
    localparam int unsigned PRESCALE_W  = 8;
    localparam int unsigned INTERVAL_W  = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [TIME_W-1:0]     WATCHDOG_GRACE          = 32'd30;
    localparam logic [PRESCALE_W-1:0] RESET_TICKS_PER_SECOND  = 8'd250;
    localparam logic [INTERVAL_W-1:0] RESET_ALARM_PERIOD      = 16'd9000;

    // Item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TICKS_PER_SECOND    = 2'd0,
        CFG_ALARM_PERIOD        = 2'd1,
        CFG_SECONDS_FLAG_ENABLE = 2'd2
    } cfg_index_t;

endpackage

[hw/rtl/seconds_clock_with_periodic_alarm_unit.sv]
// Top level of the seconds clock with periodic alarm.
// Depends on scpa_pkg; a checker is bound to it from scpa_checker.sv.
//
// Seconds clock with periodic alarm. Each input item is either a prescaler
// tick (kind = 0) or a wall-time load (kind = 1). Ticks are counted; when the
// count reaches ticks_per_second a second passes: uptime advances, the wall
// clock advances if nonzero, the watchdog is kicked when packet_time + 30 is
// at least the new uptime, second_pulse is raised if seconds_flag_enable is
// set, and a periodic alarm fires once the wall clock reaches the last alarm
// time plus the alarm period. A wall-time load replaces the wall clock,
// clears the prescaler and may raise the alarm under its own test (new time
// ahead of a nonzero clock by over last alarm time plus period). Every item
// gives exactly one result item. An item is taken into an input register,
// and once the result register is free the state update and result are
// computed in one pass and stored in the result register, so one item can
// be accepted every cycle while the result side is not stalled; the
// one-pass state update (an increment and a 32-bit compare) sets that
// rate. The input side stalls only while the input register is full and
// the result register holds an item that is itself stalled. Configuration
// writes are always accepted (cfg_ready is high) and must be made only
// while no item is in flight; an index of 3 is ignored.
module seconds_clock_with_periodic_alarm_unit (
    input  logic                                clk,
    input  logic                                rst_n,

    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [scpa_pkg::CFG_DATA_W-1:0]     cfg_data,

    // Input item channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [scpa_pkg::TIME_W-1:0]         load_time,
    input  logic [scpa_pkg::TIME_W-1:0]         packet_time,

    // Result item channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                periodic_alarm,
    output logic                                second_pulse,
    output logic                                watchdog_kick,
    output logic [scpa_pkg::TIME_W-1:0]         wall_time,
    output logic [scpa_pkg::TIME_W-1:0]         uptime_seconds
);
    import scpa_pkg::*;

    // Configuration registers
    logic [PRESCALE_W-1:0] ticks_per_second_reg;
    logic [INTERVAL_W-1:0] alarm_period_reg;
    logic                  seconds_flag_enable_reg;

    // Clock state
    logic [PRESCALE_W-1:0] prescale_count_reg, prescale_count_next;
    logic [TIME_W-1:0]     uptime_count_reg, uptime_count_next;
    logic [TIME_W-1:0]     wall_clock_reg, wall_clock_next;
    logic [TIME_W-1:0]     last_alarm_time_reg, last_alarm_time_next;

    // Input register
    logic                  in_valid_reg;
    logic                  kind_reg;
    logic [TIME_W-1:0]     load_time_reg;
    logic [TIME_W-1:0]     packet_time_reg;

    // Result register
    logic                  out_valid_reg;
    logic                  alarm_reg, alarm_next;
    logic                  pulse_reg, pulse_next;
    logic                  kick_reg, kick_next;

    logic                  in_accept;
    logic                  out_free;
    logic                  advance;

    // Intermediate values for the one-pass update
    logic [PRESCALE_W-1:0] prescale_inc;
    logic                  second_done;
    logic [TIME_W-1:0]     uptime_inc;
    logic [TIME_W-1:0]     wall_inc;
    logic [TIME_W-1:0]     alarm_target;
    logic [TIME_W-1:0]     kick_limit;
    logic [TIME_W-1:0]     set_delta;

    // Handshake: the result register frees when empty or taken this cycle,
    // and the input register drains into it whenever it frees.
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_second_reg    <= RESET_TICKS_PER_SECOND;
            alarm_period_reg        <= RESET_ALARM_PERIOD;
            seconds_flag_enable_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TICKS_PER_SECOND:
                    ticks_per_second_reg <= cfg_data[PRESCALE_W-1:0];
                CFG_ALARM_PERIOD:
                    alarm_period_reg <= cfg_data[INTERVAL_W-1:0];
                CFG_SECONDS_FLAG_ENABLE:
                    seconds_flag_enable_reg <= cfg_data[0];
                default:
                    ;   // unassigned index: drop the write
            endcase
        end
    end

    // Shared intermediate terms
    assign prescale_inc = prescale_count_reg + PRESCALE_W'(1);
    // A zero ticks_per_second makes every tick a second.
    assign second_done  = (prescale_inc >= ticks_per_second_reg);
    assign uptime_inc   = uptime_count_reg + TIME_W'(1);
    assign wall_inc     = (wall_clock_reg != '0) ? wall_clock_reg + TIME_W'(1)
                                                 : wall_clock_reg;
    assign alarm_target = last_alarm_time_reg
                        + {{(TIME_W-INTERVAL_W){1'b0}}, alarm_period_reg};
    assign kick_limit   = packet_time_reg + WATCHDOG_GRACE;
    assign set_delta    = load_time_reg - wall_clock_reg;

    // One-pass state update and result for the item in the input register
    always_comb
    begin
        prescale_count_next  = prescale_count_reg;
        uptime_count_next    = uptime_count_reg;
        wall_clock_next      = wall_clock_reg;
        last_alarm_time_next = last_alarm_time_reg;
        alarm_next           = 1'b0;
        pulse_next           = 1'b0;
        kick_next            = 1'b0;

        if (kind_reg == KIND_SET)
        begin
            // Load wall time; the alarm test compares the jump itself
            // against the alarm target.
            alarm_next          = (wall_clock_reg != '0)
                               && (load_time_reg > wall_clock_reg)
                               && (set_delta > alarm_target);
            wall_clock_next     = load_time_reg;
            prescale_count_next = '0;
        end
        else if (second_done)
        begin
            prescale_count_next = '0;
            uptime_count_next   = uptime_inc;
            wall_clock_next     = wall_inc;
            kick_next           = (kick_limit >= uptime_inc);
            pulse_next          = seconds_flag_enable_reg;
            if (wall_inc >= alarm_target)
            begin
                alarm_next           = 1'b1;
                last_alarm_time_next = wall_inc;
            end
        end
        else
        begin
            prescale_count_next = prescale_inc;
        end
    end

    // Control and clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            prescale_count_reg  <= '0;
            uptime_count_reg    <= '0;
            wall_clock_reg      <= '0;
            last_alarm_time_reg <= '0;
        end
        else
        begin
            // Input register fills on accept, empties when it drains.
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            // Result register loads on drain, empties when taken.
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                prescale_count_reg  <= prescale_count_next;
                uptime_count_reg    <= uptime_count_next;
                wall_clock_reg      <= wall_clock_next;
                last_alarm_time_reg <= last_alarm_time_next;
            end
        end
    end

    // Payload registers: hold the input item, capture the result on drain
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg        <= kind;
            load_time_reg   <= load_time;
            packet_time_reg <= packet_time;
        end
        if (advance)
        begin
            alarm_reg <= alarm_next;
            pulse_reg <= pulse_next;
            kick_reg  <= kick_next;
        end
    end

    // The result's times are the clock state right after its item.
    assign out_valid      = out_valid_reg;
    assign periodic_alarm = alarm_reg;
    assign second_pulse   = pulse_reg;
    assign watchdog_kick  = kick_reg;
    assign wall_time      = wall_clock_reg;
    assign uptime_seconds = uptime_count_reg;

endmodule

[hw/rtl/scpa_checker.sv]
// Port-level checker for the seconds clock with periodic alarm.
// Depends on scpa_pkg; bound to seconds_clock_with_periodic_alarm_unit.
module scpa_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic                              periodic_alarm,
    input logic                              second_pulse,
    input logic                              watchdog_kick,
    input logic [scpa_pkg::TIME_W-1:0]       wall_time,
    input logic [scpa_pkg::TIME_W-1:0]       uptime_seconds
);

    // No result is offered while reset is held.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result offered during reset");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(periodic_alarm)
            && $stable(second_pulse) && $stable(watchdog_kick)
            && $stable(wall_time) && $stable(uptime_seconds))
        else $error("stalled result changed");

    // The input side stalls only behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with result side free");

    // An accepted item is later followed by a result on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##2 out_valid)
        else $error("accepted item produced no result");

endmodule

bind seconds_clock_with_periodic_alarm_unit scpa_checker u_scpa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .periodic_alarm (periodic_alarm),
    .second_pulse   (second_pulse),
    .watchdog_kick  (watchdog_kick),
    .wall_time      (wall_time),
    .uptime_seconds (uptime_seconds)
);
